### hw/rtl/multilevel_feedback_scheduler_assert.svh
// Assertion macros shared by the scheduler modules.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define MLFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define MLFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

### hw/rtl/mlfs_pkg.sv
`default_nettype none
package mlfs_pkg;

  localparam int NUM_PROCS_DEF  = 16;
  localparam int NUM_LEVELS_DEF = 6;

  localparam int PID_W  = 4;
  localparam int LVL_W  = 3;
  localparam int QNT_W  = 6;
  localparam int PROC_W = 2 + LVL_W;

  localparam logic [0:0] CFG_QUANTUM_MODE     = 1'd0;
  localparam logic [0:0] CFG_CONSTANT_QUANTUM = 1'd1;

  typedef enum logic [2:0] {
    ACT_NEW     = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_IO_REQ  = 3'd2,
    ACT_IO_DONE = 3'd3,
    ACT_FINISH  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_INACTIVE = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DISP = 2'd2,
    S_RES  = 2'd3
  } state_t;

  typedef struct packed {
    logic             enq_vld;
    logic [LVL_W-1:0] enq_lvl;
    logic             deq_en;
  } qreq_t;

  typedef struct packed {
    logic             enq_ok;
    logic             found;
    logic             fwd;
    logic [LVL_W-1:0] deq_lvl;
  } qstat_t;

  function automatic logic [QNT_W-1:0] quantum_for(input logic mode,
                                                   input logic [QNT_W-1:0] cq,
                                                   input logic [LVL_W-1:0] lvl);
    logic [QNT_W-1:0] q;
    if (!mode) begin
      q = cq;
    end else if (lvl >= LVL_W'(6)) begin
      q = QNT_W'(63);
    end else begin
      q = QNT_W'(1) << lvl;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mlfs_if.sv
`default_nettype none
interface mlfs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] process_id;
  logic [2:0] start_level;
  modport source(output valid, output action, output process_id, output start_level,
                 input ready);
  modport sink(input valid, input action, input process_id, input start_level,
               output ready);
endinterface

interface mlfs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] running_process;
  logic       running_valid;
  logic       switched;
  modport source(output valid, output running_process, output running_valid,
                 output switched, input ready);
  modport sink(input valid, input running_process, input running_valid,
               input switched, output ready);
endinterface
`default_nettype wire

### hw/rtl/multilevel_feedback_scheduler.sv
// Multilevel feedback queue scheduler.
// Scheduling events arrive as transactions on in_ch (action, process_id,
// start_level). Every accepted transaction produces exactly one result
// transaction on out_ch: the running process, whether one runs, and whether
// this event dispatched a process. Queue levels are served lowest first.
// Configuration (quantum mode, constant quantum) is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce.
// Flow: an accepted transaction is worked in the EXEC state, then in the
// DISP state if the event dispatches a process (for the registered read of
// the ready-queue memory); the RES state then loads the output register.
// The next transaction is taken in the cycle after the result is loaded, so
// the block takes no new event before it is through with the last one.
// If the receiver stalls, a finished result waits in the output register
// and the block still takes one more event; that event's result then holds
// until the output register frees up.
// Reset (rst_n, synchronous, active low) empties all queues, marks every
// process inactive, leaves no process running and resets output valid and config.
`default_nettype none
`include "multilevel_feedback_scheduler_assert.svh"
module multilevel_feedback_scheduler #(
  parameter int NUM_PROCS  = mlfs_pkg::NUM_PROCS_DEF,
  parameter int NUM_LEVELS = mlfs_pkg::NUM_LEVELS_DEF
) (
  input wire logic       clk,
  input wire logic       rst_n,
  mlfs_in_if.sink        in_ch,
  mlfs_out_if.source     out_ch,
  input wire logic       cfg_we,
  input wire logic [0:0] cfg_index,
  input wire logic [5:0] cfg_wdata
);
  localparam int PIDX_W = $clog2(NUM_PROCS);
  localparam int QA_W   = $clog2(NUM_LEVELS * NUM_PROCS);
  localparam int PID_W  = mlfs_pkg::PID_W;
  localparam int LVL_W  = mlfs_pkg::LVL_W;
  localparam int QNT_W  = mlfs_pkg::QNT_W;
  localparam int PROC_W = mlfs_pkg::PROC_W;

  mlfs_pkg::state_t state_r, state_nxt;

  // Event being processed.
  logic [2:0]       act_r;
  logic [PID_W-1:0] pid_r;
  logic [LVL_W-1:0] lvl_r;

  logic             mode_r;
  logic [QNT_W-1:0] cq_r;

  // Running process.
  logic             cur_vld_r, cur_vld_nxt;
  logic [PID_W-1:0] cur_id_r, cur_id_nxt;
  logic [LVL_W-1:0] cur_lvl_r, cur_lvl_nxt;
  logic [QNT_W-1:0] rq_r, rq_nxt;

  // Pending dispatch.
  logic [LVL_W-1:0] disp_lvl_r, disp_lvl_nxt;
  logic             fwd_r, fwd_nxt;
  logic [PID_W-1:0] fwd_pid_r, fwd_pid_nxt;

  // Result waiting for the output register.
  logic [PID_W-1:0] res_pid_r, res_pid_nxt;
  logic             res_vld_r, res_vld_nxt;
  logic             res_sw_r, res_sw_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [PID_W-1:0] out_pid_r;
  logic             out_rv_r;
  logic             out_sw_r;
  logic             out_load;

  // Process table: status and level, with a valid bit per entry so that a
  // never-written entry reads as inactive at level zero.
  logic [NUM_PROCS-1:0] proc_vld_r;
  logic                 pw_en;
  logic [PIDX_W-1:0]    pw_addr;
  logic [PROC_W-1:0]    pw_data;
  logic [PIDX_W-1:0]    pr_addr;
  logic [PROC_W-1:0]    pr_data;
  logic [PROC_W-1:0]    prd;
  mlfs_pkg::status_t    pst;
  logic [LVL_W-1:0]     plv;
  logic [LVL_W-1:0]     nlv;
  logic [PIDX_W-1:0]    pidx;

  // Ready queues.
  mlfs_pkg::qreq_t  qreq;
  mlfs_pkg::qstat_t qstat;
  logic [QA_W-1:0]  enq_addr;
  logic [QA_W-1:0]  deq_addr;
  logic [PID_W-1:0] enq_pid;
  logic [PID_W-1:0] q_rdata;
  logic [PID_W-1:0] disp_pid;

  logic pid_ok;
  logic need;
  logic try_disp;
  logic [QNT_W-1:0] rq_dec;
  logic             in_acc;

  assign in_ch.ready = (state_r == mlfs_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid           = out_vld_r;
  assign out_ch.running_process = out_pid_r;
  assign out_ch.running_valid   = out_rv_r;
  assign out_ch.switched        = out_sw_r;

  assign pidx    = PIDX_W'(pid_r);
  assign pr_addr = PIDX_W'(in_ch.process_id);
  assign prd     = proc_vld_r[pidx] ? pr_data : '0;
  assign pst     = mlfs_pkg::status_t'(prd[PROC_W-1:LVL_W]);
  assign plv     = prd[LVL_W-1:0];
  assign nlv     = (32'(plv) >= NUM_LEVELS - 1) ? LVL_W'(NUM_LEVELS - 1) : plv + 1'b1;
  assign pid_ok  = 32'(pid_r) < NUM_PROCS;
  assign rq_dec  = (rq_r != '0) ? rq_r - 1'b1 : '0;

  assign disp_pid = (32'(fwd_r ? fwd_pid_r : q_rdata) < NUM_PROCS)
                    ? (fwd_r ? fwd_pid_r : q_rdata) : '0;

  mlfs_ram #(.WIDTH(PROC_W), .DEPTH(NUM_PROCS)) u_proc_ram (
    .clk  (clk),
    .we   (pw_en),
    .waddr(pw_addr),
    .wdata(pw_data),
    .raddr(pr_addr),
    .rdata(pr_data)
  );

  mlfs_ram #(.WIDTH(PID_W), .DEPTH(NUM_LEVELS * NUM_PROCS)) u_queue_ram (
    .clk  (clk),
    .we   (qstat.enq_ok && state_r == mlfs_pkg::S_EXEC),
    .waddr(enq_addr),
    .wdata(enq_pid),
    .raddr(deq_addr),
    .rdata(q_rdata)
  );

  mlfs_qctl #(.NUM_PROCS(NUM_PROCS), .NUM_LEVELS(NUM_LEVELS)) u_qctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (qreq),
    .stat    (qstat),
    .enq_addr(enq_addr),
    .deq_addr(deq_addr)
  );

  assign out_load = (state_r == mlfs_pkg::S_RES) && (!out_vld_r || out_ch.ready);

  // Next state, process-table writes, queue requests and result.
  always_comb begin
    state_nxt    = state_r;
    cur_vld_nxt  = cur_vld_r;
    cur_id_nxt   = cur_id_r;
    cur_lvl_nxt  = cur_lvl_r;
    rq_nxt       = rq_r;
    disp_lvl_nxt = disp_lvl_r;
    fwd_nxt      = fwd_r;
    fwd_pid_nxt  = fwd_pid_r;
    res_pid_nxt  = res_pid_r;
    res_vld_nxt  = res_vld_r;
    res_sw_nxt   = res_sw_r;
    pw_en        = 1'b0;
    pw_addr      = pidx;
    pw_data      = '0;
    qreq         = '0;
    enq_pid      = pid_r;
    need         = 1'b0;
    try_disp     = 1'b0;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    unique case (state_r)
      mlfs_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = mlfs_pkg::S_EXEC;
        end
      end
      mlfs_pkg::S_EXEC: begin
        case (mlfs_pkg::action_t'(act_r))
          mlfs_pkg::ACT_NEW: begin
            if (pid_ok && pst == mlfs_pkg::ST_INACTIVE) begin
              pw_en         = 1'b1;
              pw_data       = {mlfs_pkg::ST_READY, lvl_r};
              qreq.enq_vld  = 1'b1;
              qreq.enq_lvl  = lvl_r;
            end
          end
          mlfs_pkg::ACT_TICK: begin
            if (cur_vld_r) begin
              rq_nxt = rq_dec;
              if (rq_dec == '0) begin
                // Quantum used up: the process goes back to the tail of its level.
                pw_en        = 1'b1;
                pw_addr      = PIDX_W'(cur_id_r);
                pw_data      = {mlfs_pkg::ST_READY, cur_lvl_r};
                qreq.enq_vld = 1'b1;
                qreq.enq_lvl = cur_lvl_r;
                enq_pid      = cur_id_r;
                cur_vld_nxt  = 1'b0;
                need         = 1'b1;
              end
            end
          end
          mlfs_pkg::ACT_IO_REQ: begin
            if (cur_vld_r) begin
              pw_en       = 1'b1;
              pw_addr     = PIDX_W'(cur_id_r);
              pw_data     = {mlfs_pkg::ST_BLOCKED, cur_lvl_r};
              cur_vld_nxt = 1'b0;
              need        = 1'b1;
            end
          end
          mlfs_pkg::ACT_IO_DONE: begin
            if (pid_ok && pst == mlfs_pkg::ST_BLOCKED) begin
              pw_en        = 1'b1;
              pw_data      = {mlfs_pkg::ST_READY, nlv};
              qreq.enq_vld = 1'b1;
              qreq.enq_lvl = nlv;
            end
          end
          mlfs_pkg::ACT_FINISH: begin
            if (pid_ok && cur_vld_r && cur_id_r == pid_r) begin
              pw_en       = 1'b1;
              pw_data     = {mlfs_pkg::ST_INACTIVE, cur_lvl_r};
              cur_vld_nxt = 1'b0;
              need        = 1'b1;
            end
          end
          default: begin
          end
        endcase
        try_disp = need || !cur_vld_nxt;
        if (try_disp && qstat.found) begin
          qreq.deq_en  = 1'b1;
          disp_lvl_nxt = qstat.deq_lvl;
          fwd_nxt      = qstat.fwd;
          fwd_pid_nxt  = enq_pid;
          state_nxt    = mlfs_pkg::S_DISP;
        end else begin
          if (try_disp) begin
            cur_vld_nxt = 1'b0;
            cur_id_nxt  = '0;
          end
          res_pid_nxt = cur_vld_nxt ? cur_id_nxt : '0;
          res_vld_nxt = cur_vld_nxt;
          res_sw_nxt  = 1'b0;
          state_nxt   = mlfs_pkg::S_RES;
        end
      end
      mlfs_pkg::S_DISP: begin
        pw_en       = 1'b1;
        pw_addr     = PIDX_W'(disp_pid);
        pw_data     = {mlfs_pkg::ST_RUNNING, disp_lvl_r};
        cur_vld_nxt = 1'b1;
        cur_id_nxt  = disp_pid;
        cur_lvl_nxt = disp_lvl_r;
        rq_nxt      = mlfs_pkg::quantum_for(mode_r, cq_r, disp_lvl_r);
        res_pid_nxt = disp_pid;
        res_vld_nxt = 1'b1;
        res_sw_nxt  = 1'b1;
        state_nxt   = mlfs_pkg::S_RES;
      end
      mlfs_pkg::S_RES: begin
        if (out_load) begin
          out_vld_nxt = 1'b1;
          state_nxt   = mlfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mlfs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r  <= 1'b0;
      cur_id_r   <= '0;
      cur_lvl_r  <= '0;
      rq_r       <= '0;
      out_vld_r  <= 1'b0;
      proc_vld_r <= '0;
      mode_r     <= 1'b0;
      cq_r       <= QNT_W'(1);
    end else begin
      cur_vld_r <= cur_vld_nxt;
      cur_id_r  <= cur_id_nxt;
      cur_lvl_r <= cur_lvl_nxt;
      rq_r      <= rq_nxt;
      out_vld_r <= out_vld_nxt;
      if (pw_en) begin
        proc_vld_r[pw_addr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          mlfs_pkg::CFG_QUANTUM_MODE:     mode_r <= cfg_wdata[0];
          mlfs_pkg::CFG_CONSTANT_QUANTUM: cq_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_ch.action;
      pid_r <= in_ch.process_id;
      // A start level past the last queue saturates to the last queue.
      lvl_r <= (32'(in_ch.start_level) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                     : in_ch.start_level;
    end
    disp_lvl_r <= disp_lvl_nxt;
    fwd_r      <= fwd_nxt;
    fwd_pid_r  <= fwd_pid_nxt;
    res_pid_r  <= res_pid_nxt;
    res_vld_r  <= res_vld_nxt;
    res_sw_r   <= res_sw_nxt;
    if (out_load) begin
      out_pid_r <= res_pid_r;
      out_rv_r  <= res_vld_r;
      out_sw_r  <= res_sw_r;
    end
  end

  `MLFS_ASSERT_IMPL(a_sw_running, clk, rst_n, out_vld_r && out_sw_r, out_rv_r)
  `MLFS_ASSERT_IMPL(a_idle_pid_zero, clk, rst_n, out_vld_r && !out_rv_r, out_pid_r == '0)
  `MLFS_ASSERT_NEXT(a_disp_running, clk, rst_n, state_r == mlfs_pkg::S_DISP,
                    cur_vld_r && proc_vld_r[PIDX_W'(cur_id_r)])
endmodule
`default_nettype wire

### hw/rtl/mlfs_ram.sv
`default_nettype none
module mlfs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/mlfs_qctl.sv
`default_nettype none
`include "multilevel_feedback_scheduler_assert.svh"
module mlfs_qctl #(
  parameter int NUM_PROCS  = mlfs_pkg::NUM_PROCS_DEF,
  parameter int NUM_LEVELS = mlfs_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire mlfs_pkg::qreq_t                          req,
  output mlfs_pkg::qstat_t                              stat,
  output logic [$clog2(NUM_LEVELS*NUM_PROCS)-1:0]       enq_addr,
  output logic [$clog2(NUM_LEVELS*NUM_PROCS)-1:0]       deq_addr
);
  localparam int SLOT_W = $clog2(NUM_PROCS);
  localparam int CNT_W  = $clog2(NUM_PROCS + 1);
  localparam int LIDX_W = $clog2(NUM_LEVELS);
  localparam int QA_W   = $clog2(NUM_LEVELS * NUM_PROCS);

  logic [SLOT_W-1:0] head_r [NUM_LEVELS];
  logic [SLOT_W-1:0] tail_r [NUM_LEVELS];
  logic [CNT_W-1:0]  cnt_r  [NUM_LEVELS];

  logic [LIDX_W-1:0] eidx;
  logic [LIDX_W-1:0] didx;
  logic              enq_ok;
  logic              found;
  logic              deq_do;

  assign eidx   = req.enq_lvl[LIDX_W-1:0];
  assign enq_ok = req.enq_vld && (32'(req.enq_lvl) < NUM_LEVELS)
                  && (32'(cnt_r[eidx]) < NUM_PROCS);

  // The lowest level that holds an entry once this cycle's enqueue is counted.
  always_comb begin
    found = 1'b0;
    didx  = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0 || (enq_ok && eidx == LIDX_W'(l))) begin
        found = 1'b1;
        didx  = LIDX_W'(l);
      end
    end
  end

  assign deq_do       = req.deq_en && found;
  assign stat.enq_ok  = enq_ok;
  assign stat.found   = found;
  assign stat.fwd     = enq_ok && eidx == didx && cnt_r[didx] == '0;
  assign stat.deq_lvl = mlfs_pkg::LVL_W'(didx);
  assign enq_addr     = QA_W'(eidx) * QA_W'(NUM_PROCS) + QA_W'(tail_r[eidx]);
  assign deq_addr     = QA_W'(didx) * QA_W'(NUM_PROCS) + QA_W'(head_r[didx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (enq_ok && eidx == LIDX_W'(l)) begin
          tail_r[l] <= (32'(tail_r[l]) == NUM_PROCS - 1) ? '0 : tail_r[l] + 1'b1;
        end
        if (deq_do && didx == LIDX_W'(l)) begin
          head_r[l] <= (32'(head_r[l]) == NUM_PROCS - 1) ? '0 : head_r[l] + 1'b1;
        end
        cnt_r[l] <= cnt_r[l] + CNT_W'(enq_ok && eidx == LIDX_W'(l))
                             - CNT_W'(deq_do && didx == LIDX_W'(l));
      end
    end
  end

  `MLFS_ASSERT_IMPL(a_deq_found, clk, rst_n, req.deq_en, found)
  `MLFS_ASSERT_IMPL(a_fwd_enq, clk, rst_n, stat.fwd, enq_ok && found)
  `MLFS_ASSERT_IMPL(a_cnt0_max, clk, rst_n, 1'b1, 32'(cnt_r[0]) <= NUM_PROCS)
endmodule
`default_nettype wire
